/* hw/rtl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and codes of the first-fit block allocator: result codes,
// controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int STATUS_W = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_REUSED = 3'd0,
		ST_NEW    = 3'd1,
		ST_ZERO   = 3'd2,
		ST_FULL   = 3'd3,
		ST_FREED  = 3'd4,
		ST_BADH   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_READ,
		S_CHECK,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load_item;
		logic    start_scan;
		logic    rd_en;
		logic    step;
		logic    take_hit;
		logic    append;
		logic    do_free;
		logic    set_fail;
		status_t fail_code;
		logic    out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic kind_free;
		logic req_zero;
		logic count_zero;
		logic tbl_full;
		logic handle_ok;
		logic hit;
		logic idx_zero;
		logic out_free;
	} stat_t;

endpackage

/* hw/rtl/ffba_ctrl.sv */
// ----------------------------------------------------------------------------
// ffba_ctrl
// Controller of the allocator: takes a request, chooses the path, steps the
// newest-to-oldest scan and hands the result to the output register.
// ----------------------------------------------------------------------------
module ffba_ctrl
	import ffba_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.kind_free || stat.req_zero || stat.count_zero) begin
					state_d = S_DONE;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (stat.hit || stat.idx_zero) begin
					state_d = S_DONE;
				end else begin
					state_d = S_READ;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.fail_code = ST_ZERO;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load_item = s_tvalid;
			end
			S_DECIDE: begin
				if (stat.kind_free) begin
					if (stat.handle_ok) begin
						cmd.do_free = 1'b1;
					end else begin
						cmd.set_fail = 1'b1;
						cmd.fail_code = ST_BADH;
					end
				end else if (stat.req_zero) begin
					cmd.set_fail = 1'b1;
					cmd.fail_code = ST_ZERO;
				end else if (stat.count_zero) begin
					cmd.append = 1'b1;
				end else begin
					cmd.start_scan = 1'b1;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
			end
			S_CHECK: begin
				if (stat.hit) begin
					cmd.take_hit = 1'b1;
				end else if (!stat.idx_zero) begin
					cmd.step = 1'b1;
				end else if (stat.tbl_full) begin
					cmd.set_fail = 1'b1;
					cmd.fail_code = ST_FULL;
				end else begin
					cmd.append = 1'b1;
				end
			end
			S_DONE: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* hw/rtl/ffba_dpath.sv */
// ----------------------------------------------------------------------------
// ffba_dpath
// Datapath of the allocator: request registers, block table memories, block
// count, scan index, size compare, result and output registers.
// ----------------------------------------------------------------------------
module ffba_dpath
	import ffba_pkg::*;
#(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic        in_kind,
	input  logic [31:0] in_size,
	input  logic [3:0]  in_handle,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata
);

	localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int HW = (CW > 4) ? CW : 4;
	localparam int XW = (SIZE_BITS > 32) ? SIZE_BITS : 32;

	logic [SIZE_BITS-1:0] size_mem [NUM_BLOCKS];
	logic                 mark_mem [NUM_BLOCKS];

	logic                 kind_q;
	logic [SIZE_BITS-1:0] req_q;
	logic [HW-1:0]        handle_q;
	logic [CW-1:0]        count_q;
	logic [IW-1:0]        idx_q;
	logic [SIZE_BITS-1:0] rd_size_q;
	logic                 rd_mark_q;
	status_t              res_status_q;
	logic [IW-1:0]        res_handle_q;
	logic [SIZE_BITS-1:0] res_size_q;
	logic                 m_tvalid_q;
	logic [39:0]          m_tdata_q;

	logic [XW-1:0]        in_size_x;
	logic [XW-1:0]        res_size_x;
	logic [HW-1:0]        res_handle_x;
	logic [HW-1:0]        count_x;
	logic [IW-1:0]        app_idx;
	logic [CW-1:0]        last_idx;
	logic                 mark_we;
	logic [IW-1:0]        mark_waddr;
	logic                 mark_wdata;

	assign in_size_x    = XW'(in_size);
	assign res_size_x   = XW'(res_size_q);
	assign res_handle_x = HW'(res_handle_q);
	assign count_x      = HW'(count_q);
	assign app_idx      = count_q[IW-1:0];
	assign last_idx     = count_q - CW'(1);

	assign stat.kind_free  = kind_q;
	assign stat.req_zero   = (req_q == '0);
	assign stat.count_zero = (count_q == '0);
	assign stat.tbl_full   = (count_q == CW'(NUM_BLOCKS));
	assign stat.handle_ok  = (handle_q < count_x);
	assign stat.hit        = rd_mark_q && (rd_size_q >= req_q);
	assign stat.idx_zero   = (idx_q == '0);
	assign stat.out_free   = !m_tvalid_q || m_tready;

	// Only one of the three free-mark writers is active in a cycle.
	always_comb begin
		mark_we    = cmd.take_hit || cmd.append || cmd.do_free;
		mark_wdata = cmd.do_free;
		if (cmd.do_free) begin
			mark_waddr = handle_q[IW-1:0];
		end else if (cmd.append) begin
			mark_waddr = app_idx;
		end else begin
			mark_waddr = idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			size_mem[app_idx] <= req_q;
		end
		if (mark_we) begin
			mark_mem[mark_waddr] <= mark_wdata;
		end
		if (cmd.rd_en) begin
			rd_size_q <= size_mem[idx_q];
			rd_mark_q <= mark_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q   <= in_kind;
			req_q    <= in_size_x[SIZE_BITS-1:0];
			handle_q <= HW'(in_handle);
		end
		if (cmd.start_scan) begin
			idx_q <= last_idx[IW-1:0];
		end else if (cmd.step) begin
			idx_q <= idx_q - IW'(1);
		end
		if (cmd.take_hit) begin
			res_status_q <= ST_REUSED;
			res_handle_q <= idx_q;
			res_size_q   <= rd_size_q;
		end else if (cmd.append) begin
			res_status_q <= ST_NEW;
			res_handle_q <= app_idx;
			res_size_q   <= req_q;
		end else if (cmd.do_free) begin
			res_status_q <= ST_FREED;
			res_handle_q <= handle_q[IW-1:0];
			res_size_q   <= '0;
		end else if (cmd.set_fail) begin
			res_status_q <= cmd.fail_code;
			res_handle_q <= '0;
			res_size_q   <= '0;
		end
		if (cmd.out_load) begin
			m_tdata_q <= {1'b0, res_size_x[31:0], res_handle_x[3:0], res_status_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.append) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* hw/rtl/first_fit_block_allocator.sv */
// One request at a time: a request is taken when the controller is idle, even
// while the previous result still waits in the output register. A free, a
// zero-size allocate or an allocate into an empty table goes from the decide
// state straight to the done state. Any other allocate scans the block table
// from the newest block to the oldest, through a read state and a check state
// per block, as the table memory's read port is registered. The table needs no
// clearing after reset.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a table of up to NUM_BLOCKS sized blocks, built as
// a controller and a datapath.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
	import ffba_pkg::*;
#(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // request_size[31:0], handle[35:32], zero pad
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // status[2:0], granted_handle[6:3],
	                              // granted_size[38:7], zero pad
);

	cmd_t  cmd;
	stat_t stat;

	ffba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ffba_dpath #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_kind   (s_tuser),
		.in_size   (s_tdata[31:0]),
		.in_handle (s_tdata[35:32]),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
